// ----- rtl/prim_minimum_spanning_tree_core_macros.svh -----
// Assertion macros for the spanning tree core.
// Used by the top level; no dependencies.
`ifndef PRIM_MINIMUM_SPANNING_TREE_CORE_MACROS_SVH
`define PRIM_MINIMUM_SPANNING_TREE_CORE_MACROS_SVH
`ifndef SYNTH
// prop must hold at every clock edge outside reset
`define PMST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// cond must never be true outside reset
`define PMST_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PMST_ASSERT(lbl, prop, msg)
`define PMST_NEVER(lbl, cond, msg)
`endif
`endif

// ----- rtl/pmst_pkg.sv -----
// Shared types and constants of the spanning tree core.
// No dependencies.
package pmst_pkg;

  localparam logic       OP_ADD   = 1'b0;
  localparam logic       OP_RUN   = 1'b1;
  localparam int         VC_W     = 7;
  localparam logic [6:0] VC_RESET = 7'd64;
  localparam int         COST_W   = 22;
  localparam logic [21:0] COST_MAX = 22'd4194303;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD_A,
    S_ADD_B,
    S_INIT,
    S_SCAN,
    S_PICK,
    S_RELAX,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

  typedef struct packed {
    logic load_in;
    logic wr_a;
    logic wr_b;
    logic clr_start;
    logic clr_step;
    logic run_start;
    logic pass_start;
    logic init_step;
    logic scan_step;
    logic pick;
    logic relax_step;
    logic emit_addr;
    logic emit_ld;
  } cmd_t;

  typedef struct packed {
    logic idx_end;
    logic pipe_busy;
    logic clr_end;
    logic add_ok;
    logic steps_done;
    logic out_free;
    logic last_item;
  } sts_t;

endpackage

// ----- rtl/pmst_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pmst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/pmst_ctrl.sv -----
// Sequencer of the spanning tree core: load, clear, Prim passes, emit.
// Depends on pmst_pkg.
module pmst_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_opcode,
  input  pmst_pkg::sts_t sts,
  output pmst_pkg::cmd_t cmd
);
  import pmst_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        if (sts.clr_end) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.clr_step = 1'b1;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_opcode == OP_RUN) begin
            cmd.run_start  = 1'b1;
            cmd.pass_start = 1'b1;
            state_nxt      = S_INIT;
          end else begin
            cmd.load_in = 1'b1;
            state_nxt   = S_ADD_A;
          end
        end
      end
      S_ADD_A: begin
        if (sts.add_ok) begin
          cmd.wr_a  = 1'b1;
          state_nxt = S_ADD_B;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_ADD_B: begin
        cmd.wr_b  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_INIT: begin
        if (!sts.idx_end) begin
          cmd.init_step = 1'b1;
        end else begin
          cmd.pass_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts.idx_end) begin
          cmd.scan_step = 1'b1;
        end else if (!sts.pipe_busy) begin
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        cmd.pick       = 1'b1;
        cmd.pass_start = 1'b1;
        state_nxt      = S_RELAX;
      end
      S_RELAX: begin
        if (!sts.idx_end) begin
          cmd.relax_step = 1'b1;
        end else if (!sts.pipe_busy) begin
          if (sts.steps_done) begin
            state_nxt = S_EMIT_RD;
          end else begin
            cmd.pass_start = 1'b1;
            state_nxt      = S_SCAN;
          end
        end
      end
      S_EMIT_RD: begin
        cmd.emit_addr = 1'b1;
        state_nxt     = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        cmd.emit_addr = 1'b1;
        if (sts.out_free) begin
          cmd.emit_ld = 1'b1;
          if (sts.last_item) begin
            cmd.clr_start = 1'b1;
            state_nxt     = S_CLEAR;
          end else begin
            state_nxt = S_EMIT_RD;
          end
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

endmodule

// ----- rtl/pmst_dp.sv -----
// Datapath of the spanning tree core: stores, scan and relax pipes, output.
// Depends on pmst_pkg and pmst_ram.
module pmst_dp #(
  parameter int MAX_VERTICES = 64,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [6:0]          cfg_wdata,
  input  logic [5:0]          in_end_a,
  input  logic [5:0]          in_end_b,
  input  logic [15:0]         in_weight,
  input  pmst_pkg::cmd_t      cmd,
  output pmst_pkg::sts_t      sts,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [5:0]          out_parent_vertex,
  output logic [5:0]          out_child_vertex,
  output logic [15:0]         out_edge_weight,
  output logic [21:0]         out_total_cost,
  output logic                out_unreachable,
  output logic                out_has_edge,
  output logic                out_last
);
  import pmst_pkg::*;

  localparam int VW   = $clog2(MAX_VERTICES);
  localparam int NW   = $clog2(MAX_VERTICES + 1);
  localparam int AD   = MAX_VERTICES * MAX_VERTICES;
  localparam int AW   = $clog2(AD);
  localparam int KW   = WEIGHT_BITS + 1;
  localparam int SUMW = ((KW > COST_W) ? KW : COST_W) + 1;
  localparam logic [KW-1:0] KEY_INF = {1'b1, {WEIGHT_BITS{1'b0}}};

  logic [VC_W-1:0]        vc_r;
  logic [NW-1:0]          nv;
  logic [5:0]             a_r, b_r;
  logic [WEIGHT_BITS-1:0] w_r;
  logic [31:0]            w_ext;
  logic [AW:0]            clr_r;
  logic [NW-1:0]          idx_r, step_r;
  logic [VW-1:0]          vd_r, sel_r, bsel_r, ff_r, e_r, sel_c;
  logic                   scan_v_r, relax_v_r, found_r, ff_found_r;
  logic [KW-1:0]          best_r;
  logic [MAX_VERTICES-1:0] in_tree_r, unr_r;
  logic [COST_W-1:0]      cost_r;

  logic                   adj_we, key_we, rlx_we;
  logic [AW-1:0]          adj_waddr, adj_raddr;
  logic [WEIGHT_BITS-1:0] adj_wdata, adj_q;
  logic [VW-1:0]          key_waddr, key_raddr;
  logic [KW-1:0]          key_wdata, key_q;
  logic [VW-1:0]          par_q;
  logic [31:0]            k_ext;
  logic [SUMW-1:0]        sum;
  logic [COST_W-1:0]      cost_sat;

  assign w_ext = 32'(in_weight);

  always_comb begin
    if (vc_r == '0) begin
      nv = NW'(1);
    end else if (int'(vc_r) > MAX_VERTICES) begin
      nv = NW'(MAX_VERTICES);
    end else begin
      nv = NW'(vc_r);
    end
  end

  // adjacency store
  always_comb begin
    adj_we    = cmd.clr_step | cmd.wr_a | cmd.wr_b;
    adj_wdata = cmd.clr_step ? '0 : w_r;
    if (cmd.clr_step) begin
      adj_waddr = clr_r[AW-1:0];
    end else if (cmd.wr_a) begin
      adj_waddr = AW'(int'(a_r) * MAX_VERTICES + int'(b_r));
    end else begin
      adj_waddr = AW'(int'(b_r) * MAX_VERTICES + int'(a_r));
    end
    adj_raddr = AW'(int'(sel_r) * MAX_VERTICES + int'(idx_r[VW-1:0]));
  end

  pmst_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(AD)) u_adj (
    .clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
    .raddr(adj_raddr), .rdata(adj_q)
  );

  // key and parent stores
  assign rlx_we = relax_v_r && (adj_q != '0) && !in_tree_r[vd_r] && (KW'(adj_q) < key_q);

  always_comb begin
    key_we    = cmd.init_step | rlx_we;
    key_waddr = cmd.init_step ? idx_r[VW-1:0] : vd_r;
    if (cmd.init_step) begin
      key_wdata = (idx_r == '0) ? '0 : KEY_INF;
    end else begin
      key_wdata = KW'(adj_q);
    end
    key_raddr = cmd.emit_addr ? e_r : idx_r[VW-1:0];
  end

  pmst_ram #(.WIDTH(KW), .DEPTH(MAX_VERTICES)) u_key (
    .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
    .raddr(key_raddr), .rdata(key_q)
  );

  pmst_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_par (
    .clk(clk), .we(rlx_we), .waddr(vd_r), .wdata(sel_r),
    .raddr(key_raddr), .rdata(par_q)
  );

  assign sel_c    = found_r ? bsel_r : ff_r;
  assign k_ext    = 32'(key_q);
  assign sum      = SUMW'(cost_r) + SUMW'(key_q);
  assign cost_sat = (sum > SUMW'(COST_MAX)) ? COST_MAX : sum[COST_W-1:0];

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r      <= VC_RESET;
      clr_r     <= '0;
      scan_v_r  <= 1'b0;
      relax_v_r <= 1'b0;
      in_tree_r <= '0;
      unr_r     <= '0;
      out_valid <= 1'b0;
      idx_r     <= '0;
      step_r    <= '0;
      e_r       <= '0;
      cost_r    <= '0;
    end else begin
      if (cfg_we) begin
        vc_r <= cfg_wdata;
      end
      if (cmd.clr_start) begin
        clr_r <= '0;
      end else if (cmd.clr_step) begin
        clr_r <= clr_r + 1'b1;
      end
      scan_v_r  <= cmd.scan_step;
      relax_v_r <= cmd.relax_step;
      if (cmd.pass_start) begin
        idx_r <= '0;
      end else if (cmd.init_step | cmd.scan_step | cmd.relax_step) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.run_start) begin
        in_tree_r <= '0;
        unr_r     <= '0;
        step_r    <= '0;
        e_r       <= VW'(1);
        cost_r    <= '0;
      end
      if (cmd.pick) begin
        in_tree_r[sel_c] <= 1'b1;
        if (!found_r) begin
          unr_r[sel_c] <= 1'b1;
        end
        step_r <= step_r + 1'b1;
      end
      if (cmd.emit_ld) begin
        out_valid <= 1'b1;
        e_r       <= e_r + 1'b1;
        if (nv != NW'(1) && !unr_r[e_r]) begin
          cost_r <= cost_sat;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      a_r <= in_end_a;
      b_r <= in_end_b;
      w_r <= w_ext[WEIGHT_BITS-1:0];
    end
    if (cmd.scan_step | cmd.relax_step) begin
      vd_r <= idx_r[VW-1:0];
    end
    if (cmd.pass_start) begin
      found_r    <= 1'b0;
      ff_found_r <= 1'b0;
      best_r     <= KEY_INF;
    end else if (scan_v_r && !in_tree_r[vd_r]) begin
      if (!ff_found_r) begin
        ff_r       <= vd_r;
        ff_found_r <= 1'b1;
      end
      if (key_q < best_r) begin
        best_r  <= key_q;
        bsel_r  <= vd_r;
        found_r <= 1'b1;
      end
    end
    if (cmd.pick) begin
      sel_r <= sel_c;
    end
    if (cmd.emit_ld) begin
      out_last <= sts.last_item;
      if (nv == NW'(1)) begin
        out_parent_vertex <= '0;
        out_child_vertex  <= '0;
        out_edge_weight   <= '0;
        out_total_cost    <= '0;
        out_unreachable   <= 1'b0;
        out_has_edge      <= 1'b0;
      end else if (unr_r[e_r]) begin
        out_parent_vertex <= '0;
        out_child_vertex  <= 6'(e_r);
        out_edge_weight   <= '0;
        out_total_cost    <= cost_r;
        out_unreachable   <= 1'b1;
        out_has_edge      <= 1'b1;
      end else begin
        out_parent_vertex <= 6'(par_q);
        out_child_vertex  <= 6'(e_r);
        out_edge_weight   <= k_ext[15:0];
        out_total_cost    <= cost_sat;
        out_unreachable   <= 1'b0;
        out_has_edge      <= 1'b1;
      end
    end
  end

  always_comb begin
    sts.idx_end    = (idx_r == nv);
    sts.pipe_busy  = scan_v_r | relax_v_r;
    sts.clr_end    = (clr_r == (AW + 1)'(AD));
    sts.add_ok     = (int'(a_r) < MAX_VERTICES) && (int'(b_r) < MAX_VERTICES) && (a_r != b_r);
    sts.steps_done = (step_r == nv);
    sts.out_free   = !out_valid || out_ready;
    sts.last_item  = (nv == NW'(1)) || (NW'(e_r) == nv - 1'b1);
  end

endmodule

// ----- rtl/prim_minimum_spanning_tree_core.sv -----
// Minimum spanning tree core (Prim's algorithm over an adjacency matrix).
// Edges are loaded one transfer at a time (opcode add) into a symmetric
// MAX_VERTICES x MAX_VERTICES weight RAM; weight 0 removes an edge, a later
// edge for a pair overwrites it. A run transfer grows the tree from vertex 0
// over vertex_count vertices (0 taken as 1, clamped to MAX_VERTICES) and then
// emits one transfer per vertex 1..V-1 in order: parent, child, weight,
// saturating running cost, and last. Vertices not connected to vertex 0 come
// out flagged unreachable with weight 0. A one-vertex run emits a single
// transfer with has_edge 0. A run makes one key init pass, then for each
// selected vertex one key scan and one matrix row relax, each a pass over
// the vertices through the registered RAM read, then emits its transfers;
// a clearing pass over all MAX_VERTICES^2 weight RAM entries follows
// before the next input transfer is taken. The same clearing pass runs
// after reset. vertex_count is written through cfg_we / cfg_wdata.
// Depends on pmst_pkg, pmst_ctrl, pmst_dp, pmst_ram and the macros header.
`include "prim_minimum_spanning_tree_core_macros.svh"
module prim_minimum_spanning_tree_core #(
  parameter int MAX_VERTICES = 64,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [5:0]  in_end_a,
  input  logic [5:0]  in_end_b,
  input  logic [15:0] in_weight,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_parent_vertex,
  output logic [5:0]  out_child_vertex,
  output logic [15:0] out_edge_weight,
  output logic [21:0] out_total_cost,
  output logic        out_unreachable,
  output logic        out_has_edge,
  output logic        out_last
);
  import pmst_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: owns the state machine and the input handshake
  pmst_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_opcode(in_opcode), .sts(sts), .cmd(cmd)
  );

  // stores, scan/relax pipes, cost accumulator and output register
  pmst_dp #(.MAX_VERTICES(MAX_VERTICES), .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_end_a(in_end_a), .in_end_b(in_end_b), .in_weight(in_weight),
    .cmd(cmd), .sts(sts), .out_valid(out_valid), .out_ready(out_ready),
    .out_parent_vertex(out_parent_vertex), .out_child_vertex(out_child_vertex),
    .out_edge_weight(out_edge_weight), .out_total_cost(out_total_cost),
    .out_unreachable(out_unreachable), .out_has_edge(out_has_edge),
    .out_last(out_last)
  );

  // an emit never overwrites a result still waiting for its transfer
  `PMST_NEVER(a_no_overwrite, cmd.emit_ld && out_valid && !out_ready, "result overwritten")
  // a new result shows up only after an emit load
  `PMST_ASSERT(a_valid_src, $rose(out_valid) |-> $past(cmd.emit_ld), "spurious out_valid")
  // no input is taken while the weight RAM is being cleared
  `PMST_NEVER(a_no_in_clr, in_ready && cmd.clr_step, "input during clear")
  // edge writes never overlap a relax pass
  `PMST_NEVER(a_no_wr_relax, (cmd.wr_a || cmd.wr_b) && cmd.relax_step, "write in relax")

endmodule

// ----- dv/pmst_checker.sv -----
// Spanning tree checker: watches both channels, computes expected tree edges.
// Depends on pmst_pkg; instantiated by tb_prim_minimum_spanning_tree_core.
`timescale 1ns / 100ps
module pmst_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_opcode,
  input  logic [5:0]  in_end_a,
  input  logic [5:0]  in_end_b,
  input  logic [15:0] in_weight,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [5:0]  out_parent_vertex,
  input  logic [5:0]  out_child_vertex,
  input  logic [15:0] out_edge_weight,
  input  logic [21:0] out_total_cost,
  input  logic        out_unreachable,
  input  logic        out_has_edge,
  input  logic        out_last,
  output int          fail_count,
  output int          pending_edges
);
  import pmst_pkg::*;

  typedef struct packed {
    logic [5:0]  parent;
    logic [5:0]  child;
    logic [15:0] weight;
    logic [21:0] cost;
    logic        unreach;
    logic        has_edge;
    logic        last;
  } tree_edge_t;

  localparam int NV_MAX  = 64;
  localparam int KEY_INF = 65536;

  logic [15:0] graph [NV_MAX][NV_MAX];
  logic [6:0]  vcount;
  tree_edge_t  tree_q[$];

  task automatic grow_tree();
    int nv, best, pick, cost;
    int key [NV_MAX];
    int par [NV_MAX];
    bit joined [NV_MAX];
    bit lost [NV_MAX];
    tree_edge_t t;
    nv = (vcount == 0) ? 1 : ((vcount > NV_MAX) ? NV_MAX : vcount);
    for (int v = 0; v < NV_MAX; v++) begin
      key[v] = KEY_INF; par[v] = 0; joined[v] = 0; lost[v] = 0;
    end
    key[0] = 0;
    for (int s = 0; s < nv; s++) begin
      best = KEY_INF; pick = -1;
      for (int v = 0; v < nv; v++)
        if (!joined[v] && key[v] < best) begin
          best = key[v]; pick = v;
        end
      // nothing reachable left: lowest remaining vertex, flagged
      if (pick < 0) begin
        for (int v = nv - 1; v >= 0; v--) if (!joined[v]) pick = v;
        lost[pick] = 1;
      end
      joined[pick] = 1;
      for (int v = 0; v < nv; v++)
        if (graph[pick][v] != 0 && !joined[v] && graph[pick][v] < key[v]) begin
          key[v] = graph[pick][v]; par[v] = pick;
        end
    end
    if (nv == 1) begin
      t = '0; t.last = 1;
      tree_q.push_back(t);
    end else begin
      cost = 0;
      for (int i = 1; i < nv; i++) begin
        t = '0;
        t.child = 6'(i); t.has_edge = 1; t.last = (i == nv - 1);
        if (lost[i]) t.unreach = 1;
        else begin
          cost += key[i];
          if (cost > COST_MAX) cost = COST_MAX;
          t.parent = 6'(par[i]); t.weight = 16'(key[i]);
        end
        t.cost = 22'(cost);
        tree_q.push_back(t);
      end
    end
    for (int a = 0; a < NV_MAX; a++)
      for (int b = 0; b < NV_MAX; b++) graph[a][b] = '0;
  endtask

  always @(posedge clk) begin
    tree_edge_t e;
    if (!rst_n) begin
      for (int a = 0; a < NV_MAX; a++)
        for (int b = 0; b < NV_MAX; b++) graph[a][b] = '0;
      vcount = VC_RESET;
      tree_q.delete();
      fail_count    <= 0;
      pending_edges <= 0;
    end else begin
      if (cfg_we) vcount = cfg_wdata;
      if (in_valid && in_ready) begin
        if (in_opcode == OP_RUN) grow_tree();
        else if (in_end_a != in_end_b) begin
          graph[in_end_a][in_end_b] = in_weight;
          graph[in_end_b][in_end_a] = in_weight;
        end
      end
      if (out_valid && out_ready) begin
        if (tree_q.size() == 0) begin
          $error("unexpected tree edge transfer");
          fail_count <= fail_count + 1;
        end else begin
          e = tree_q.pop_front();
          if (out_parent_vertex !== e.parent || out_child_vertex !== e.child ||
              out_edge_weight !== e.weight || out_total_cost !== e.cost ||
              out_unreachable !== e.unreach || out_has_edge !== e.has_edge ||
              out_last !== e.last) begin
            fail_count <= fail_count + 1;
            if (out_parent_vertex !== e.parent)
              $error("parent_vertex exp %0d got %0d", e.parent, out_parent_vertex);
            if (out_child_vertex !== e.child)
              $error("child_vertex exp %0d got %0d", e.child, out_child_vertex);
            if (out_edge_weight !== e.weight)
              $error("edge_weight exp %0d got %0d", e.weight, out_edge_weight);
            if (out_total_cost !== e.cost)
              $error("total_cost exp %0d got %0d", e.cost, out_total_cost);
            if (out_unreachable !== e.unreach)
              $error("unreachable exp %0d got %0d", e.unreach, out_unreachable);
            if (out_has_edge !== e.has_edge)
              $error("has_edge exp %0d got %0d", e.has_edge, out_has_edge);
            if (out_last !== e.last)
              $error("last exp %0d got %0d", e.last, out_last);
          end
        end
      end
      pending_edges <= tree_q.size();
    end
  end
endmodule

// ----- dv/tb_prim_minimum_spanning_tree_core.sv -----
// Stimulus and verdict for the spanning tree core: loads graphs edge by edge,
// runs the tree at several vertex counts. Depends on pmst_pkg, pmst_checker.
`timescale 1ns / 100ps
module tb_prim_minimum_spanning_tree_core;
  import pmst_pkg::*;

  localparam int STALL_LIMIT = 200000;  // covers clearing pass + 64-vertex run

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [6:0]  cfg_wdata = '0;
  logic        in_valid = 0;
  logic        in_ready;
  logic        in_opcode = OP_ADD;
  logic [5:0]  in_end_a = '0;
  logic [5:0]  in_end_b = '0;
  logic [15:0] in_weight = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [5:0]  out_parent_vertex, out_child_vertex;
  logic [15:0] out_edge_weight;
  logic [21:0] out_total_cost;
  logic        out_unreachable, out_has_edge, out_last;
  int          fail_count, pending_edges;
  int          idle_cycles;
  bit          calm;       // no idling on either side while set

  always #2 clk = ~clk;

  prim_minimum_spanning_tree_core dut (.*);

  pmst_checker u_chk (.*);

  // watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side backpressure, ~25% stall
  always @(posedge clk)
    out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 25);

  // one transfer; random idle gap first, valid held until accepted
  task automatic send(input logic op, input logic [5:0] a, input logic [5:0] b,
                      input logic [15:0] w);
    while (!calm && $urandom_range(99) < 25) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid  <= 1;
    in_opcode <= op;
    in_end_a  <= a;
    in_end_b  <= b;
    in_weight <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending_edges != 0) @(posedge clk);
    repeat (5000) @(posedge clk);  // covers clearing pass after the last run
  endtask

  task automatic set_vertices(input logic [6:0] n);
    drain();
    cfg_we    <= 1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // random graph on n vertices, mostly in-range, some noise
  task automatic random_graph(input int n, input int edges);
    logic [5:0] a, b;
    for (int k = 0; k < edges; k++) begin
      a = 6'($urandom_range(n - 1));
      b = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(n - 1));
      if ($urandom_range(9) == 0) b = a;  // self loop, ignored
      send(OP_ADD, a, b, ($urandom_range(3) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(1, 9)));
    end
    send(OP_RUN, 6'($urandom), 6'($urandom), 16'($urandom));
  endtask

  initial begin
    int n;
    calm = 0;
    idle_cycles = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;

    // reset count of 64, empty graph: everything unreachable
    send(OP_RUN, 6'd0, 6'd0, 16'd0);
    // one-vertex graph; 0 also taken as 1
    set_vertices(7'd1);
    send(OP_ADD, 6'd0, 6'd63, 16'hFFFF);
    send(OP_RUN, 6'd63, 6'd63, 16'hFFFF);
    set_vertices(7'd0);
    send(OP_RUN, 6'd0, 6'd0, 16'd0);
    // above 64 clamps; heavy chain stays below the cost limit, self loop ignored
    set_vertices(7'd127);
    for (int v = 1; v < 64; v++) send(OP_ADD, 6'(v - 1), 6'(v), 16'hFFFF);
    send(OP_ADD, 6'd5, 6'd5, 16'd1);      // self loop
    send(OP_RUN, 6'd0, 6'd0, 16'd0);
    // ties and equal weights, small graph, one vertex disconnected
    set_vertices(7'd5);
    send(OP_ADD, 6'd0, 6'd1, 16'd3);
    send(OP_ADD, 6'd0, 6'd2, 16'd3);
    send(OP_ADD, 6'd1, 6'd2, 16'd3);
    send(OP_ADD, 6'd2, 6'd3, 16'd7);
    send(OP_ADD, 6'd3, 6'd2, 16'd2);      // overwrite
    send(OP_ADD, 6'd0, 6'd3, 16'd9);
    send(OP_ADD, 6'd0, 6'd3, 16'd0);      // removal
    send(OP_ADD, 6'd4, 6'd40, 16'd1);     // beyond vertex count
    send(OP_RUN, 6'd0, 6'd0, 16'd0);

    // random phase: first stretch without idling
    calm = 1;
    for (int r = 0; r < 7; r++) begin
      if (r == 3) calm = 0;
      n = ($urandom_range(5) == 0) ? $urandom_range(20, 64) : $urandom_range(2, 8);
      set_vertices(7'(n));
      random_graph(n, $urandom_range(4, 12));
    end

    drain();
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
